>>> design/ntc_adc_to_temperature_unit_macros.svh
// Assertion helpers for ntc_adc_to_temperature_unit.
`ifndef NTC_ADC_TO_TEMPERATURE_UNIT_MACROS_SVH
`define NTC_ADC_TO_TEMPERATURE_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define NTC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that one condition is followed by another on the next clock edge.
`define NTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ntc_a2t_pkg.sv
// ----------------------------------------------------------------------------
// ntc_a2t_pkg
// Shared types and constants of the NTC ADC to temperature converter.
// ----------------------------------------------------------------------------
package ntc_a2t_pkg;

  // Q16 fraction bits of the logarithm, Q31 mantissa width
  localparam int unsigned LOG_FRAC = 16;
  localparam int unsigned MANT_W   = 32;

  // Quotient bits produced by the divider (Kelvin result in 0.01 K)
  localparam int unsigned QUOT_W = 16;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  localparam logic signed [14:0] TEMP_MIN     = -15'sd4000;
  localparam logic signed [14:0] TEMP_MAX     = 15'sd12500;
  localparam logic signed [14:0] TEMP_OPEN    = -15'sd9900;
  localparam logic signed [14:0] TEMP_SHORT   = 15'sd9900;
  localparam logic signed [14:0] TEMP_TIMEOUT = 15'sd2500;
  localparam logic signed [17:0] KELVIN_OFS   = 18'sd27315;

  typedef enum logic [1:0] {
    ST_NORMAL  = 2'd0,
    ST_OPEN    = 2'd1,
    ST_SHORT   = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_FULL_SCALE = 3'd0,
    REG_PULLUP     = 3'd1,
    REG_NOMINAL    = 3'd2,
    REG_BETA       = 3'd3,
    REG_REF_TEMP   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic    valid;
    status_e status;
  } meta_t;

endpackage

>>> design/ntc_a2t_log2.sv
// ----------------------------------------------------------------------------
// ntc_a2t_log2
// Pipelined base-2 logarithm in Q16: normalize, then one squaring per stage.
// ----------------------------------------------------------------------------
module ntc_a2t_log2 #(
  parameter int unsigned W = 36
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [W-1:0]                    x_i,
  output logic [$clog2(W)+ntc_a2t_pkg::LOG_FRAC-1:0] log_o
);
  import ntc_a2t_pkg::*;

  localparam int unsigned PW = $clog2(W);

  logic [W-1:0]        xz;
  logic [PW-1:0]       msb;
  logic [W+30:0]       ext;

  logic [MANT_W-1:0]   m_q [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] f_q [LOG_FRAC+1];
  logic [PW-1:0]       p_q [LOG_FRAC+1];

  // Leading one position, zero taken as one
  always_comb begin
    xz  = (x_i == '0) ? W'(1) : x_i;
    msb = '0;
    for (int i = 0; i < W; i++) begin
      if (xz[i]) msb = PW'(i);
    end
    ext = {xz, 31'b0} >> msb;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= ext[MANT_W-1:0];
      p_q[0] <= msb;
      f_q[0] <= '0;
    end
  end

  for (genvar s = 1; s <= LOG_FRAC; s++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;
    always_comb begin
      sq = m_q[s-1] * m_q[s-1];
      t  = sq[2*MANT_W-1:MANT_W-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[s] <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
        f_q[s] <= {f_q[s-1][LOG_FRAC-2:0], t[MANT_W]};
        p_q[s] <= p_q[s-1];
      end
    end
  end

  assign log_o = {p_q[LOG_FRAC], f_q[LOG_FRAC]};

endmodule

>>> design/ntc_a2t_div.sv
// ----------------------------------------------------------------------------
// ntc_a2t_div
// Pipelined restoring divider, one quotient bit per stage, with a pass flag.
// ----------------------------------------------------------------------------
module ntc_a2t_div #(
  parameter int unsigned NW  = 54,
  parameter int unsigned DVW = 43
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [NW-1:0]                  num_i,
  input  logic [DVW-1:0]                 den_i,
  input  logic                           sat_i,
  output logic [ntc_a2t_pkg::QUOT_W-1:0] quot_o,
  output logic                           sat_o
);
  import ntc_a2t_pkg::*;

  localparam int unsigned CW = ((NW > DVW + QUOT_W) ? NW : DVW + QUOT_W) + 1;

  logic [CW-1:0]     r_q   [QUOT_W];
  logic [DVW-1:0]    d_q   [QUOT_W];
  logic [QUOT_W-1:0] q_q   [QUOT_W];
  logic              sat_q [QUOT_W];

  for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
    localparam int unsigned K = QUOT_W - 1 - s;
    logic [CW-1:0]     r_in;
    logic [DVW-1:0]    d_in;
    logic [QUOT_W-1:0] q_in;
    logic              sat_in;
    logic [CW-1:0]     dsh;
    logic              take;
    if (s == 0) begin : g_first
      assign r_in   = CW'(num_i);
      assign d_in   = den_i;
      assign q_in   = '0;
      assign sat_in = sat_i;
    end else begin : g_next
      assign r_in   = r_q[s-1];
      assign d_in   = d_q[s-1];
      assign q_in   = q_q[s-1];
      assign sat_in = sat_q[s-1];
    end
    assign dsh  = CW'(d_in) << K;
    assign take = (r_in >= dsh);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]   <= take ? (r_in - dsh) : r_in;
        d_q[s]   <= d_in;
        q_q[s]   <= q_in | (QUOT_W'(take) << K);
        sat_q[s] <= sat_in;
      end
    end
  end

  assign quot_o = q_q[QUOT_W-1];
  assign sat_o  = sat_q[QUOT_W-1];

endmodule

>>> design/ntc_adc_to_temperature_unit.sv
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature_unit
// NTC divider ADC code to temperature in 0.01 degC by the beta equation.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry the ADC code in s_axis_tdata and the read-succeeded
//   flag in s_axis_tuser[0]. Each input beat gives one output beat with the
//   temperature (signed 0.01 degC) in m_axis_tdata and status / clamp flag
//   in m_axis_tuser. Registers are to be written over the APB port only while
//   idle; the block itself does not enforce this.
// Pipeline: 1 classify/multiply stage, 17 logarithm stages (normalize plus one
//   squaring multiplier per fraction bit), 7 stages forming ln and the
//   divisor, 16 divider stages (one quotient bit each), 1 output register.
// Throughput: one beat per cycle while the output does not stall; the squaring
//   multipliers and divider subtractors are each replicated per stage.
// Reset: clears the valid bits and loads the register defaults; results in
//   flight are dropped.
// Stall: while a result waits in the output register and the receiver holds
//   tready low, the whole pipeline holds and tready on the input side drops.
// ----------------------------------------------------------------------------
`include "ntc_adc_to_temperature_unit_macros.svh"

module ntc_adc_to_temperature_unit #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [4:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((ADC_BITS+7)/8)*8-1:0]     s_axis_tdata,  // adc_code, zero pad
  input  logic [0:0]                        s_axis_tuser,  // read_ok
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,  // temp_centi, zero pad
  output logic [2:0]                        m_axis_tuser   // status, clamped
);
  import ntc_a2t_pkg::*;

  localparam int unsigned X1W   = 20 + ADC_BITS;
  localparam int unsigned L1W   = $clog2(X1W) + LOG_FRAC;
  localparam int unsigned L2W   = $clog2(16) + LOG_FRAC;
  localparam int unsigned L3W   = $clog2(20) + LOG_FRAC;
  localparam int unsigned LBW   = $clog2(X1W) + LOG_FRAC + 2;
  localparam int unsigned PW    = LBW + 18;
  localparam int unsigned DW    = LBW + 20;
  localparam int unsigned DVW   = DW - 1;
  localparam int unsigned NW    = 53;
  localparam int unsigned CW    = DVW + QUOT_W + 1;
  // side line spans input stage, log lanes, ln/divisor stages, divider
  localparam int unsigned DEPTH = 1 + (LOG_FRAC + 1) + 7 + QUOT_W;

  // ---------------------------------------------------------------- registers
  logic [15:0] fs_q, t0_q;
  logic [19:0] pu_q, nom_q;
  logic [13:0] beta_q;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q   <= 16'd4095;
      pu_q   <= 20'd10000;
      nom_q  <= 20'd10000;
      beta_q <= 14'd3950;
      t0_q   <= 16'd29815;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_FULL_SCALE: fs_q   <= pwdata[15:0];
        REG_PULLUP:     pu_q   <= pwdata[19:0];
        REG_NOMINAL:    nom_q  <= pwdata[19:0];
        REG_BETA:       beta_q <= pwdata[13:0];
        REG_REF_TEMP:   t0_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_FULL_SCALE: prdata = 32'(fs_q);
      REG_PULLUP:     prdata = 32'(pu_q);
      REG_NOMINAL:    prdata = 32'(nom_q);
      REG_BETA:       prdata = 32'(beta_q);
      REG_REF_TEMP:   prdata = 32'(t0_q);
      default:        prdata = '0;
    endcase
  end

  // zero registers act as one
  logic [19:0] pu, nom;
  logic [13:0] beta;
  logic [15:0] t0;
  assign pu   = (pu_q == '0)   ? 20'd1 : pu_q;
  assign nom  = (nom_q == '0)  ? 20'd1 : nom_q;
  assign beta = (beta_q == '0) ? 14'd1 : beta_q;
  assign t0   = (t0_q == '0)   ? 16'd1 : t0_q;

  // ---------------------------------------------------------------- flow
  // Advance every stage together whenever the output register can move.
  logic en;
  logic m_valid_q;
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  meta_t side_q [DEPTH];

  // ---------------------------------------------------------------- stage 1
  logic [ADC_BITS-1:0] code;
  logic [23:0]         c100, f99;
  status_e             st_d;

  assign code = s_axis_tdata[ADC_BITS-1:0];
  assign c100 = 24'(code) * 24'd100;
  assign f99  = 24'(fs_q) * 24'd99;

  always_comb begin
    if (!s_axis_tuser[0])          st_d = ST_TIMEOUT;
    else if (c100 >= f99)          st_d = ST_OPEN;
    else if (c100 <= 24'(fs_q))    st_d = ST_SHORT;
    else                           st_d = ST_NORMAL;
  end

  logic [X1W-1:0] x1_q;
  logic [15:0]    x2_q;
  logic [19:0]    x3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q <= X1W'(pu) * X1W'(code);
      x2_q <= fs_q - 16'(code);
      x3_q <= nom;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) side_q[i] <= '{valid: 1'b0, status: ST_NORMAL};
    end else if (en) begin
      side_q[0] <= '{valid: s_axis_tvalid, status: st_d};
      for (int i = 1; i < DEPTH; i++) side_q[i] <= side_q[i-1];
    end
  end

  // ---------------------------------------------------------------- logarithms
  logic [L1W-1:0] lg1;
  logic [L2W-1:0] lg2;
  logic [L3W-1:0] lg3;

  ntc_a2t_log2 #(.W(X1W)) u_log_num (.clk_i, .en_i(en), .x_i(x1_q), .log_o(lg1));
  ntc_a2t_log2 #(.W(16))  u_log_den (.clk_i, .en_i(en), .x_i(x2_q), .log_o(lg2));
  ntc_a2t_log2 #(.W(20))  u_log_nom (.clk_i, .en_i(en), .x_i(x3_q), .log_o(lg3));

  // ---------------------------------------------------------------- ln, divisor
  logic signed [LBW-1:0] l_q;
  logic                  neg_q, neg2_q;
  logic [LBW-1:0]        mag_q;
  logic [LBW+29:0]       pln_q;
  logic [LBW+29:0]       pln_rnd;
  logic [LBW-1:0]        lnmag;
  logic signed [LBW:0]   lnq_q;
  logic signed [PW-1:0]  p2_q;
  logic [29:0]           tb_q;
  logic signed [DW-1:0]  den_q;
  logic [NW-1:0]         num_q;
  logic [DW-1:0]         bsc;

  assign pln_rnd = pln_q + (LBW+30)'(1 << 29);
  assign lnmag   = pln_rnd[LBW+29:30];
  assign bsc     = DW'(beta) * DW'(100);

  // stage feeding the divider
  logic [DVW-1:0] dv;
  logic [NW:0]    n2;
  logic           nonpos, ovf;
  logic [NW:0]    n2_q;
  logic [DVW-1:0] dv_q;
  logic           sat_q;

  assign nonpos = den_q[DW-1] || (den_q == '0);
  assign dv     = den_q[DVW-1:0];
  assign n2     = (NW+1)'(num_q) + (NW+1)'(dv >> 1);
  assign ovf    = CW'(n2) >= (CW'(dv) << QUOT_W);

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_q    <= $signed(LBW'(lg1)) - $signed(LBW'(lg2)) - $signed(LBW'(lg3));
      neg_q  <= l_q[LBW-1];
      mag_q  <= l_q[LBW-1] ? LBW'(-l_q) : LBW'(l_q);
      pln_q  <= (LBW+30)'(mag_q) * (LBW+30)'(LN2_Q30);
      neg2_q <= neg_q;
      lnq_q  <= neg2_q ? -$signed({1'b0, lnmag}) : $signed({1'b0, lnmag});
      p2_q   <= PW'(lnq_q) * $signed(PW'({1'b0, t0}));
      tb_q   <= 30'(t0) * 30'(beta);
      den_q  <= $signed(bsc << LOG_FRAC) + DW'(p2_q);
      num_q  <= (NW'(tb_q) * NW'(100)) << LOG_FRAC;
      n2_q   <= n2;
      dv_q   <= dv;
      sat_q  <= nonpos || ovf;
    end
  end

  // ---------------------------------------------------------------- divider
  logic [QUOT_W-1:0] tk;
  logic              sat_o;

  ntc_a2t_div #(.NW(NW+1), .DVW(DVW)) u_div (
    .clk_i, .en_i(en), .num_i(n2_q), .den_i(dv_q), .sat_i(sat_q),
    .quot_o(tk), .sat_o(sat_o)
  );

  // ---------------------------------------------------------------- output
  logic signed [17:0] tc;
  logic signed [14:0] temp_d, temp_q;
  logic               clamp_d, clamp_q;
  status_e            st_q;
  meta_t              last;

  assign last = side_q[DEPTH-1];
  assign tc   = $signed({2'b00, tk}) - KELVIN_OFS;

  always_comb begin
    clamp_d = 1'b0;
    case (last.status)
      ST_TIMEOUT: temp_d = TEMP_TIMEOUT;
      ST_OPEN:    temp_d = TEMP_OPEN;
      ST_SHORT:   temp_d = TEMP_SHORT;
      default: begin
        if (sat_o || tc > 18'(TEMP_MAX)) begin
          temp_d  = TEMP_MAX;
          clamp_d = 1'b1;
        end else if (tc < 18'(TEMP_MIN)) begin
          temp_d  = TEMP_MIN;
          clamp_d = 1'b1;
        end else begin
          temp_d  = tc[14:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      temp_q  <= temp_d;
      clamp_q <= clamp_d;
      st_q    <= last.status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, temp_q};
  assign m_axis_tuser  = {clamp_q, st_q};

  // ---------------------------------------------------------------- checks
  `NTC_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, side_q[0].valid, "accepted beat did not enter the pipeline")
  `NTC_ASSERT(a_clamp_limits, clk_i, rst_ni, (m_valid_q && clamp_q) |-> (temp_q == TEMP_MIN || temp_q == TEMP_MAX), "clamp flag without a limit value")
  `NTC_ASSERT(a_clamp_normal, clk_i, rst_ni, (m_valid_q && clamp_q) |-> (st_q == ST_NORMAL), "clamp flag on a sentinel result")
  `NTC_ASSERT(a_timeout_val, clk_i, rst_ni, (m_valid_q && st_q == ST_TIMEOUT) |-> (temp_q == TEMP_TIMEOUT), "timeout result with wrong value")
  `NTC_ASSERT(a_normal_range, clk_i, rst_ni, (m_valid_q && st_q == ST_NORMAL) |-> (temp_q >= TEMP_MIN && temp_q <= TEMP_MAX), "normal result out of range")

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NTC ADC code to temperature converter: drives
// random and corner ADC beats through several register settings, predicts
// each temperature with an independent fixed-point model and compares it
// against every output beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import ntc_a2t_pkg::*;

// Expected temperatures in arrival order, plus the mismatch count
class temp_scoreboard;
  logic [15:0] exp_data[$];
  logic [2:0]  exp_user[$];
  int          errors = 0;

  function void note_reading(logic [15:0] data, logic [2:0] user);
    exp_data.push_back(data);
    exp_user.push_back(user);
  endfunction

  function void check_beat(logic [15:0] data, logic [2:0] user);
    logic [15:0] ed;
    logic [2:0]  eu;
    if (exp_data.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected beat data=%h user=%h", data, user);
      return;
    end
    ed = exp_data.pop_front();
    eu = exp_user.pop_front();
    if (ed !== data || eu !== user) begin
      errors++;
      if (errors <= 10)
        $display("mismatch temp exp=%h act=%h  status/clamp exp=%h act=%h",
                 ed, data, eu, user);
    end
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // adc_code, zero pad
  logic [0:0]  s_axis_tuser = '0;  // read_ok
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // temp_centi, zero pad
  logic [2:0]  m_axis_tuser;       // status, clamped

  // shadow of the converter registers
  logic [15:0] cfg_full_scale;
  logic [19:0] cfg_pullup;
  logic [19:0] cfg_nominal;
  logic [13:0] cfg_beta;
  logic [15:0] cfg_t0;

  temp_scoreboard sb = new();
  int  cycles = 0;
  bit  sink_idle_on = 1'b1;
  bit  hold_off = 1'b0;

  always #5 clk_i = ~clk_i;

  ntc_adc_to_temperature_unit i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // log2 in Q16: integer part from the top set bit, fraction by squaring
  function automatic longint log2_q16(longint unsigned x);
    int unsigned     msb;
    longint unsigned mant;
    longint          frac;
    msb = 0;
    frac = 0;
    if (x == 0) x = 1;
    while (msb < 63 && (x >> (msb + 1)) != 0) msb++;
    mant = (msb >= 31) ? (x >> (msb - 31)) : (x << (31 - msb));
    for (int i = 0; i < 16; i++) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= 64'h1_0000_0000) begin
        frac = frac | 1;
        mant = mant >> 1;
      end
    end
    return longint'(msb) * 65536 + frac;
  endfunction

  // Predict one output beat {user, data} from one input beat
  function automatic void predict_temperature(logic ok, logic [11:0] code,
                                              output logic [15:0] data,
                                              output logic [2:0] user);
    longint          temp, pu, nom, b, t0, l, lnq, den, num;
    longint unsigned mag;
    status_e         st;
    logic            clamp;
    clamp = 1'b0;
    st = ST_NORMAL;
    temp = 0;
    if (!ok) begin
      temp = 2500; st = ST_TIMEOUT;
    end else if (100 * longint'(code) >= 99 * longint'(cfg_full_scale)) begin
      temp = -9900; st = ST_OPEN;
    end else if (100 * longint'(code) <= longint'(cfg_full_scale)) begin
      temp = 9900; st = ST_SHORT;
    end else begin
      // zero registers act as one
      pu  = (cfg_pullup  == 0) ? 1 : cfg_pullup;
      nom = (cfg_nominal == 0) ? 1 : cfg_nominal;
      b   = (cfg_beta    == 0) ? 1 : cfg_beta;
      t0  = (cfg_t0      == 0) ? 1 : cfg_t0;
      l = log2_q16(pu * code) - log2_q16(cfg_full_scale - code) - log2_q16(nom);
      mag = (l < 0) ? -l : l;
      lnq = longint'((mag * 64'd744261118 + (64'd1 << 29)) >> 30);
      if (l < 0) lnq = -lnq;
      den = 100 * b * 65536 + lnq * t0;
      if (den <= 0) begin
        temp = 12500; clamp = 1'b1;   // infinitely hot
      end else begin
        num = 100 * t0 * b * 65536;
        temp = (num + den / 2) / den - 27315;
        if (temp < -4000) begin
          temp = -4000; clamp = 1'b1;
        end else if (temp > 12500) begin
          temp = 12500; clamp = 1'b1;
        end
      end
    end
    data = {1'b0, temp[14:0]};
    user = {clamp, st};
  endfunction

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Check every output beat at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tuser);
  end

  // Receiver: random stalls, optional long hold-off
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (sink_idle_on) m_axis_tready <= ($urandom_range(0, 99) >= 36);
    else m_axis_tready <= 1'b1;
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(4 * idx); pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_FULL_SCALE: cfg_full_scale = value[15:0];
      REG_PULLUP:     cfg_pullup     = value[19:0];
      REG_NOMINAL:    cfg_nominal    = value[19:0];
      REG_BETA:       cfg_beta       = value[13:0];
      default:        cfg_t0         = value[15:0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_all(logic [15:0] fs, logic [19:0] pu, logic [19:0] nom,
                         logic [13:0] beta, logic [15:0] t0);
    write_reg(REG_FULL_SCALE, fs);
    write_reg(REG_PULLUP, pu);
    write_reg(REG_NOMINAL, nom);
    write_reg(REG_BETA, beta);
    write_reg(REG_REF_TEMP, t0);
  endtask

  // Offer one beat at the falling edge, hold until accepted; an idle gap in the
  // next call or drain() drops tvalid
  task automatic send_reading(logic ok, logic [11:0] code, bit may_idle);
    logic [15:0] ed;
    logic [2:0]  eu;
    while (may_idle && $urandom_range(0, 99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, code};
    s_axis_tuser  <= ok;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_temperature(ok, code, ed, eu);
    sb.note_reading(ed, eu);
    @(negedge clk_i);
  endtask

  // Wait for all results, then an idle tail of TAIL_CYCLES, bounded by the cycle limit
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.exp_data.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  // Code across the interesting span: near short/open thresholds or anywhere
  function automatic logic [11:0] pick_code();
    int unsigned fs;
    fs = (cfg_full_scale > 4095) ? 4095 : cfg_full_scale;
    case ($urandom_range(0, 5))
      0: return 12'($urandom_range(0, fs / 100 + 2));
      1: return 12'($urandom_range((fs * 99) / 100 - 2 < 0 ? 0 : (fs * 99) / 100 - 2, fs));
      2: return 12'($urandom_range(0, 4095));
      default: return 12'($urandom_range(fs / 100 + 1, fs));
    endcase
  endfunction

  initial begin
    logic [11:0] dir_codes[$];
    int          n;
    cfg_full_scale = 16'd4095; cfg_pullup = 20'd10000; cfg_nominal = 20'd10000;
    cfg_beta = 14'd3950; cfg_t0 = 16'd29815;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: timeout, short, open, thresholds, extremes, reset settings
    dir_codes = '{12'd0, 12'd40, 12'd41, 12'd42, 12'd100, 12'd1000, 12'd2047,
                  12'd2048, 12'd3000, 12'd4000, 12'd4053, 12'd4054, 12'd4055,
                  12'd4094, 12'd4095, 12'hAAA, 12'h555};
    send_reading(1'b0, 12'hFFF, 1'b0);
    send_reading(1'b0, 12'h000, 1'b0);
    foreach (dir_codes[i]) send_reading(1'b1, dir_codes[i], 1'b0);
    drain();

    // Extreme settings: very cold and very hot outcomes, zero registers
    set_all(16'd255, 20'd100, 20'd1000000, 14'd10000, 16'd20000);
    for (int i = 0; i < 4; i++) send_reading(1'b1, 12'($urandom_range(0, 300)), 1'b0);
    send_reading(1'b1, 12'd128, 1'b0);
    drain();
    set_all(16'd65535, 20'd1000000, 20'd100, 14'd1000, 16'd40000);
    send_reading(1'b1, 12'd4095, 1'b0);
    send_reading(1'b1, 12'd700, 1'b0);
    drain();
    set_all(16'd0, 20'd0, 20'd0, 14'd0, 16'd0);
    send_reading(1'b1, 12'd5, 1'b0);
    send_reading(1'b1, 12'd0, 1'b0);
    drain();

    // Random phases, each with fresh settings
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) set_all(16'd4095, 20'd10000, 20'd10000, 14'd3950, 16'd29815);
      else set_all(16'($urandom_range(255, 65535) >> ($urandom_range(0, 1) * 4)),
                   20'($urandom_range(100, 1000000)), 20'($urandom_range(100, 1000000)),
                   14'($urandom_range(1000, 10000)), 16'($urandom_range(20000, 40000)));
      sink_idle_on = (ph != 3);   // one phase runs flat out
      if (ph == 5) begin
        // Long receiver hold-off while the sender keeps offering beats
        fork
          begin
            hold_off = 1'b1;
            repeat (200) @(negedge clk_i);
            hold_off = 1'b0;
          end
          for (int k = 0; k < 60; k++) send_reading(1'b1, pick_code(), 1'b0);
        join
      end
      n = 100;
      for (int k = 0; k < n; k++)
        send_reading($urandom_range(0, 15) != 0, pick_code(), ph != 3);
      drain();
    end

    if (sb.errors == 0 && sb.exp_data.size() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule
